[rtl/cto_pkg.sv]
package cto_pkg;

   localparam int unsigned WorkW = 18;
   localparam int unsigned PcW   = 5;
   localparam int unsigned ModW  = 9;
   localparam int unsigned RecW  = 21;
   localparam int unsigned RecSh = 24;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_MUL,
      OP_CARRY,
      OP_MIDNIGHT,
      OP_MON_BACK,
      OP_YR_BACK,
      OP_YR_FWD,
      OP_MON_PREV,
      OP_MON_NEXT,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      SRC_SEC,
      SRC_MIN,
      SRC_HR,
      SRC_MON,
      SRC_YEAR
   } src_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_SEC_LEAP,
      C_DAY_SMALL,
      C_MON_ZERO,
      C_DAY_POS,
      C_FITS_YEAR,
      C_FITS_MONTH
   } cond_type;

   typedef struct packed {
      op_type           op;
      src_type          src;
      cond_type         cond;
      logic             rpt;
      logic [PcW-1:0]   target;
   } ucw_type;

   typedef struct packed {
      op_type  op;
      src_type src;
   } ctl_type;

   typedef struct packed {
      logic sec_leap;
      logic day_small;
      logic mon_zero;
      logic day_pos;
      logic fits_year;
      logic fits_month;
   } flags_type;

   // jump targets
   localparam logic [PcW-1:0] StMinDiv   = 5'd3;
   localparam logic [PcW-1:0] StYrBack   = 5'd16;
   localparam logic [PcW-1:0] StYrFwd    = 5'd17;
   localparam logic [PcW-1:0] StMonPrev  = 5'd18;
   localparam logic [PcW-1:0] StMonNext  = 5'd19;
   localparam logic [PcW-1:0] StDone     = 5'd20;
   localparam logic [PcW-1:0] StNone     = 5'd0;

   function automatic ucw_type mk(op_type op, src_type src, cond_type cond, logic rpt,
                                  logic [PcW-1:0] target);
      ucw_type w;
      w.op     = op;
      w.src    = src;
      w.cond   = cond;
      w.rpt    = rpt;
      w.target = target;
      return w;
   endfunction

   // microprogram
   function automatic ucw_type ucode(logic [PcW-1:0] pc);
      ucw_type w;
      unique case (pc)
         5'd0:  w = mk(OP_NOP,      SRC_SEC,  C_SEC_LEAP,   1'b0, StMinDiv);
         5'd1:  w = mk(OP_MUL,      SRC_SEC,  C_NEVER,      1'b0, StNone);
         5'd2:  w = mk(OP_CARRY,    SRC_SEC,  C_NEVER,      1'b0, StNone);
         5'd3:  w = mk(OP_MUL,      SRC_MIN,  C_NEVER,      1'b0, StNone);
         5'd4:  w = mk(OP_CARRY,    SRC_MIN,  C_NEVER,      1'b0, StNone);
         5'd5:  w = mk(OP_MUL,      SRC_YEAR, C_NEVER,      1'b0, StNone);
         5'd6:  w = mk(OP_CARRY,    SRC_YEAR, C_NEVER,      1'b0, StNone);
         5'd7:  w = mk(OP_MIDNIGHT, SRC_SEC,  C_NEVER,      1'b0, StNone);
         5'd8:  w = mk(OP_MUL,      SRC_HR,   C_NEVER,      1'b0, StNone);
         5'd9:  w = mk(OP_CARRY,    SRC_HR,   C_NEVER,      1'b0, StNone);
         5'd10: w = mk(OP_MUL,      SRC_MON,  C_NEVER,      1'b0, StNone);
         5'd11: w = mk(OP_CARRY,    SRC_MON,  C_NEVER,      1'b0, StNone);
         5'd12: w = mk(OP_MUL,      SRC_YEAR, C_NEVER,      1'b0, StNone);
         5'd13: w = mk(OP_CARRY,    SRC_YEAR, C_NEVER,      1'b0, StNone);
         5'd14: w = mk(OP_NOP,      SRC_SEC,  C_DAY_SMALL,  1'b0, StMonPrev);
         5'd15: w = mk(OP_MON_BACK, SRC_SEC,  C_MON_ZERO,   1'b1, StYrBack);
         5'd16: w = mk(OP_YR_BACK,  SRC_SEC,  C_DAY_POS,    1'b1, StYrFwd);
         5'd17: w = mk(OP_YR_FWD,   SRC_SEC,  C_FITS_YEAR,  1'b1, StMonPrev);
         5'd18: w = mk(OP_MON_PREV, SRC_SEC,  C_DAY_POS,    1'b1, StMonNext);
         5'd19: w = mk(OP_MON_NEXT, SRC_SEC,  C_FITS_MONTH, 1'b1, StDone);
         default: w = mk(OP_DONE,   SRC_SEC,  C_NEVER,      1'b0, StNone);
      endcase
      return w;
   endfunction

   function automatic logic [ModW-1:0] div_base(src_type src);
      logic [ModW-1:0] b;
      unique case (src)
         SRC_SEC:  b = 9'd60;
         SRC_MIN:  b = 9'd60;
         SRC_HR:   b = 9'd24;
         SRC_MON:  b = 9'd12;
         SRC_YEAR: b = 9'd400;
         default:  b = 9'd60;
      endcase
      return b;
   endfunction

   // floor(2^RecSh / base)
   function automatic logic [RecW-1:0] div_recip(src_type src);
      logic [RecW-1:0] m;
      unique case (src)
         SRC_SEC:  m = 21'd279620;
         SRC_MIN:  m = 21'd279620;
         SRC_HR:   m = 21'd699050;
         SRC_MON:  m = 21'd1398101;
         SRC_YEAR: m = 21'd41943;
         default:  m = 21'd279620;
      endcase
      return m;
   endfunction

   // r is the full year modulo 400
   function automatic logic is_leap(logic [ModW-1:0] r);
      return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
   endfunction

   function automatic logic [4:0] month_len(logic signed [WorkW-1:0] m, logic leap);
      logic [3:0] idx;
      logic [4:0] len;
      idx = (m < 0 || m > 11) ? 4'd0 : m[3:0];
      unique case (idx)
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[rtl/calendar_time_normalizer.sv]
// Calendar time normaliser.
// req_ carries one broken-down time per word: six signed 16-bit fields that
// may lie out of range. rsp_ returns one word per request with every field
// normalised (seconds 0..60, minutes, hours, day of month, month, year from
// 1900 on 17 bits).
// One request is worked on at a time; req_tready is high whenever the
// sequencer is idle, also while a finished word still waits on rsp_.
// Seconds of exactly 60 skip the seconds carry. The day is brought into its
// month by stepping months; when the day magnitude exceeds 366, the month is
// first stepped back to zero and whole years are stepped as well. A new word
// is taken from the cycle after the result is loaded. The year and month
// stepping loops of the microcode take one step per cycle; each floor carry
// takes a multiply step and a carry step through the shared
// reciprocal-multiply divider.
// If rsp_tready is low the result word is held in the output register; a
// later item runs to its final step and then waits there until the
// register frees up.
// Reset clears the sequencer and the output valid; no clearing pass.
module calendar_time_normalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sec_in[15:0], min_in[31:16], hour_in[47:32], day_in[63:48],
   // month_in[79:64], year_in[95:80]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22],
   // year[42:26], zero[47:43]
   output logic [47:0] rsp_tdata
);

   logic                 req_fire;
   logic                 busy;
   logic                 done;
   logic                 out_free;
   cto_pkg::ctl_type     ctl;
   cto_pkg::flags_type   flags;

   logic [5:0]           second;
   logic [5:0]           minute;
   logic [4:0]           hour;
   logic [4:0]           day;
   logic [3:0]           month;
   logic signed [16:0]   year;

   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0]          rsp_tdata_ff,  rsp_tdata_in;

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   cto_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .out_free (out_free),
      .flags    (flags),
      .ctl      (ctl),
      .busy     (busy),
      .done     (done)
   );

   cto_dp u_dp (
      .clock    (clock),
      .load     (req_fire),
      .sec_in   (req_tdata[15:0]),
      .min_in   (req_tdata[31:16]),
      .hour_in  (req_tdata[47:32]),
      .day_in   (req_tdata[63:48]),
      .month_in (req_tdata[79:64]),
      .year_in  (req_tdata[95:80]),
      .ctl      (ctl),
      .flags    (flags),
      .second   (second),
      .minute   (minute),
      .hour     (hour),
      .day      (day),
      .month    (month),
      .year     (year)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (done) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {5'b0, year, month, day, hour, minute, second};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("sequencer idle after accepting a word");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:22] <= 4'd11)
      else $error("month out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:0] <= 6'd60) && (rsp_tdata[11:6] <= 6'd59) &&
                     (rsp_tdata[16:12] <= 5'd23) && (rsp_tdata[21:17] != 5'd0))
      else $error("time field out of range");

   a_done_when_free: assert property (@(posedge clock) disable iff (reset)
      done |-> busy && out_free)
      else $error("result loaded over a pending word");

endmodule

[rtl/cto_div.sv]
module cto_div (
   input  logic                                 clock,
   input  logic                                 start,
   input  logic signed [cto_pkg::WorkW-1:0]     x,
   input  cto_pkg::src_type                     src,
   output logic signed [cto_pkg::WorkW-1:0]     q,
   output logic        [cto_pkg::ModW-1:0]      r
);

   localparam int W  = cto_pkg::WorkW;
   localparam int AW = W - 1;
   localparam int PW = AW + cto_pkg::RecW;
   localparam int QW = PW - cto_pkg::RecSh;
   localparam int BW = cto_pkg::ModW;

   logic          neg_ff;
   logic [AW-1:0] mag_ff;
   logic [PW-1:0] prod_ff;

   logic signed [W-1:0] neg_x;
   logic [AW-1:0]       mag;
   logic [QW-1:0]       q_est;
   logic [QW-1:0]       q_mag;
   logic [W-1:0]        q_b;
   logic [W-1:0]        rem0;
   logic [BW-1:0]       r_mag;
   logic [BW-1:0]       base;

   assign neg_x = -x;
   assign mag   = x[W-1] ? neg_x[AW-1:0] : x[AW-1:0];

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= x[W-1];
         mag_ff  <= mag;
         prod_ff <= PW'(mag) * PW'(cto_pkg::div_recip(src));
      end
   end

   // estimate is exact or one low
   always_comb begin
      base  = cto_pkg::div_base(src);
      q_est = prod_ff[PW-1:cto_pkg::RecSh];
      q_b   = W'(q_est) * W'(base);
      rem0  = W'(mag_ff) - q_b;
      if (rem0 >= W'(base)) begin
         q_mag = q_est + 1'b1;
         r_mag = BW'(rem0 - W'(base));
      end else begin
         q_mag = q_est;
         r_mag = BW'(rem0);
      end
      if (!neg_ff) begin
         q = $signed(W'(q_mag));
         r = r_mag;
      end else if (r_mag == '0) begin
         q = -$signed(W'(q_mag));
         r = '0;
      end else begin
         q = -$signed(W'(q_mag)) - W'(1);
         r = base - r_mag;
      end
   end

endmodule

[rtl/cto_dp.sv]
module cto_dp (
   input  logic                      clock,
   input  logic                      load,
   input  logic signed [15:0]        sec_in,
   input  logic signed [15:0]        min_in,
   input  logic signed [15:0]        hour_in,
   input  logic signed [15:0]        day_in,
   input  logic signed [15:0]        month_in,
   input  logic signed [15:0]        year_in,
   input  cto_pkg::ctl_type          ctl,
   output cto_pkg::flags_type        flags,
   output logic [5:0]                second,
   output logic [5:0]                minute,
   output logic [4:0]                hour,
   output logic [4:0]                day,
   output logic [3:0]                month,
   output logic signed [16:0]        year
);

   localparam int W  = cto_pkg::WorkW;
   localparam int BW = cto_pkg::ModW;

   logic signed [W-1:0] t_sec_ff, t_sec_in;
   logic signed [W-1:0] t_min_ff, t_min_in;
   logic signed [W-1:0] t_hr_ff,  t_hr_in;
   logic signed [W-1:0] t_day_ff, t_day_in;
   logic signed [W-1:0] t_mon_ff, t_mon_in;
   logic signed [W-1:0] t_yr_ff,  t_yr_in;
   logic [BW-1:0]       r400_ff,  r400_in;

   logic signed [W-1:0] div_x;
   logic signed [W-1:0] div_q;
   logic [BW-1:0]       div_r;
   logic signed [W-1:0] r_ext;

   logic [BW-1:0]       r400_up;
   logic [BW-1:0]       r400_dn;
   logic                leap_now;
   logic                leap_dn;
   logic signed [W-1:0] ylen_now;
   logic signed [W-1:0] ylen_dn;
   logic signed [W-1:0] mlen_now;
   logic signed [W-1:0] mon_dn;
   logic signed [W-1:0] mon_prev;
   logic signed [W-1:0] mlen_dn;
   logic signed [W-1:0] mlen_prev;
   logic signed [W-1:0] day_inc;
   logic                mon_valid;

   always_comb begin
      unique case (ctl.src)
         cto_pkg::SRC_SEC:  div_x = t_sec_ff;
         cto_pkg::SRC_MIN:  div_x = t_min_ff;
         cto_pkg::SRC_HR:   div_x = t_hr_ff;
         cto_pkg::SRC_MON:  div_x = t_mon_ff;
         cto_pkg::SRC_YEAR: div_x = t_yr_ff + W'(1900);
         default:           div_x = t_sec_ff;
      endcase
   end

   cto_div u_div (
      .clock (clock),
      .start (ctl.op == cto_pkg::OP_MUL),
      .x     (div_x),
      .src   (ctl.src),
      .q     (div_q),
      .r     (div_r)
   );

   assign r_ext     = $signed(W'(div_r));
   assign r400_up   = (r400_ff == 9'd399) ? '0 : r400_ff + 1'b1;
   assign r400_dn   = (r400_ff == '0) ? 9'd399 : r400_ff - 1'b1;
   assign leap_now  = cto_pkg::is_leap(r400_ff);
   assign leap_dn   = cto_pkg::is_leap(r400_dn);
   assign ylen_now  = W'(365) + W'(leap_now);
   assign ylen_dn   = W'(365) + W'(leap_dn);
   assign mlen_now  = $signed(W'(cto_pkg::month_len(t_mon_ff, leap_now)));
   assign mon_dn    = t_mon_ff - W'(1);
   assign mon_prev  = (t_mon_ff == 0) ? W'(11) : mon_dn;
   assign mlen_dn   = $signed(W'(cto_pkg::month_len(mon_dn, leap_now)));
   assign mlen_prev = $signed(W'(cto_pkg::month_len(mon_prev, leap_now)));
   assign day_inc   = t_day_ff + W'(1);
   assign mon_valid = (t_mon_ff >= 0) && (t_mon_ff <= 11);

   always_comb begin
      t_sec_in = t_sec_ff;
      t_min_in = t_min_ff;
      t_hr_in  = t_hr_ff;
      t_day_in = t_day_ff;
      t_mon_in = t_mon_ff;
      t_yr_in  = t_yr_ff;
      r400_in  = r400_ff;
      if (load) begin
         t_sec_in = W'(sec_in);
         t_min_in = W'(min_in);
         t_hr_in  = W'(hour_in);
         t_day_in = W'(day_in);
         t_mon_in = W'(month_in);
         t_yr_in  = W'(year_in);
      end else begin
         unique case (ctl.op)
            cto_pkg::OP_CARRY: begin
               unique case (ctl.src)
                  cto_pkg::SRC_SEC: begin
                     t_sec_in = r_ext;
                     t_min_in = t_min_ff + div_q;
                  end
                  cto_pkg::SRC_MIN: begin
                     t_min_in = r_ext;
                     t_hr_in  = t_hr_ff + div_q;
                  end
                  cto_pkg::SRC_HR: begin
                     t_hr_in  = r_ext;
                     t_day_in = t_day_ff + div_q;
                  end
                  cto_pkg::SRC_MON: begin
                     t_mon_in = r_ext;
                     t_yr_in  = t_yr_ff + div_q;
                  end
                  default: r400_in = div_r;
               endcase
            end
            cto_pkg::OP_MIDNIGHT: begin
               if (t_hr_ff == 24 && t_min_ff == 0 && t_sec_ff == 0) begin
                  t_hr_in  = '0;
                  t_day_in = day_inc;
                  if (mon_valid && day_inc > mlen_now) begin
                     t_day_in = W'(1);
                     if (t_mon_ff == 11) begin
                        t_mon_in = '0;
                        t_yr_in  = t_yr_ff + W'(1);
                     end else begin
                        t_mon_in = t_mon_ff + W'(1);
                     end
                  end
               end
            end
            cto_pkg::OP_MON_BACK: begin
               t_mon_in = mon_dn;
               t_day_in = t_day_ff + mlen_dn;
            end
            cto_pkg::OP_YR_BACK: begin
               t_yr_in  = t_yr_ff - W'(1);
               r400_in  = r400_dn;
               t_day_in = t_day_ff + ylen_dn;
            end
            cto_pkg::OP_YR_FWD: begin
               t_yr_in  = t_yr_ff + W'(1);
               r400_in  = r400_up;
               t_day_in = t_day_ff - ylen_now;
            end
            cto_pkg::OP_MON_PREV: begin
               t_mon_in = mon_prev;
               t_day_in = t_day_ff + mlen_prev;
               if (t_mon_ff == 0) begin
                  t_yr_in = t_yr_ff - W'(1);
                  r400_in = r400_dn;
               end
            end
            cto_pkg::OP_MON_NEXT: begin
               t_day_in = t_day_ff - mlen_now;
               if (t_mon_ff == 11) begin
                  t_mon_in = '0;
                  t_yr_in  = t_yr_ff + W'(1);
                  r400_in  = r400_up;
               end else begin
                  t_mon_in = t_mon_ff + W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      t_sec_ff <= t_sec_in;
      t_min_ff <= t_min_in;
      t_hr_ff  <= t_hr_in;
      t_day_ff <= t_day_in;
      t_mon_ff <= t_mon_in;
      t_yr_ff  <= t_yr_in;
      r400_ff  <= r400_in;
   end

   always_comb begin
      flags.sec_leap   = (t_sec_ff == 60);
      flags.day_small  = (t_day_ff <= 366) && (t_day_ff >= -366);
      flags.mon_zero   = (t_mon_ff == 0);
      flags.day_pos    = (t_day_ff >= 1);
      flags.fits_year  = (t_day_ff <= ylen_now);
      flags.fits_month = (t_day_ff <= mlen_now);
   end

   assign second = t_sec_ff[5:0];
   assign minute = t_min_ff[5:0];
   assign hour   = t_hr_ff[4:0];
   assign day    = t_day_ff[4:0];
   assign month  = t_mon_ff[3:0];
   assign year   = t_yr_ff[16:0];

endmodule

[rtl/cto_seq.sv]
module cto_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                out_free,
   input  cto_pkg::flags_type  flags,
   output cto_pkg::ctl_type    ctl,
   output logic                busy,
   output logic                done
);

   localparam int PW = cto_pkg::PcW;

   logic          busy_ff, busy_in;
   logic [PW-1:0] pc_ff,   pc_in;

   cto_pkg::ucw_type cw;
   logic             cond_true;

   assign cw = cto_pkg::ucode(pc_ff);

   always_comb begin
      unique case (cw.cond)
         cto_pkg::C_NEVER:      cond_true = 1'b0;
         cto_pkg::C_ALWAYS:     cond_true = 1'b1;
         cto_pkg::C_SEC_LEAP:   cond_true = flags.sec_leap;
         cto_pkg::C_DAY_SMALL:  cond_true = flags.day_small;
         cto_pkg::C_MON_ZERO:   cond_true = flags.mon_zero;
         cto_pkg::C_DAY_POS:    cond_true = flags.day_pos;
         cto_pkg::C_FITS_YEAR:  cond_true = flags.fits_year;
         cto_pkg::C_FITS_MONTH: cond_true = flags.fits_month;
         default:               cond_true = 1'b0;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      ctl.op  = cto_pkg::OP_NOP;
      ctl.src = cw.src;
      done    = 1'b0;
      if (start) begin
         pc_in   = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cond_true) begin
            pc_in = cw.target;
         end else if (cw.op == cto_pkg::OP_DONE) begin
            if (out_free) begin
               done    = 1'b1;
               busy_in = 1'b0;
            end
         end else begin
            ctl.op = cw.op;
            pc_in  = cw.rpt ? pc_ff : pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

endmodule
